FILE: hdl/line_rasterizer_three_mode_assert.svh
// Assertion macros for the line rasterizer checker.
// Depends on nothing; included by the checker file only.
`ifndef LINE_RASTERIZER_THREE_MODE_ASSERT_SVH
`define LINE_RASTERIZER_THREE_MODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LR3_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Next-cycle implication, disabled while reset is low.
`define LR3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

FILE: hdl/lr3_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies.
`default_nettype none
package lr3_pkg;
    localparam int COORD_BITS_DEF    = 12;
    localparam int DDA_FRAC_BITS_DEF = 20;
    localparam int COLOR_W           = 24;
    localparam int CFG_DATA_W        = 24;
    localparam int CFG_IDX_W         = 1;

    typedef enum logic [1:0] {
        METH_NONE   = 2'd0,
        METH_DDA    = 2'd1,
        METH_MID    = 2'd2,
        METH_DIRECT = 2'd3
    } t_method;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_METHOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic fin;
    } t_dp_sts;
endpackage
`default_nettype wire

FILE: hdl/lr3_in_if.sv
// Input channel: line loads and pixel ticks.
// Depends on lr3_pkg.
`default_nettype none
interface lr3_in_if
    import lr3_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

FILE: hdl/lr3_out_if.sv
// Output channel: one pixel per beat.
// Depends on lr3_pkg.
`default_nettype none
interface lr3_out_if
    import lr3_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]           color;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, color, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, color, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/lr3_dp.sv
// Datapath: line setup, slope divider, and per-pixel stepping for all methods.
// Depends on lr3_pkg.
`default_nettype none
module lr3_dp
    import lr3_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DDA_FRAC_BITS = DDA_FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire t_dp_cmd                      i_cmd,
    input  wire t_method                      i_method,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    output t_dp_sts                           o_sts,
    output logic signed [COORD_BITS-1:0]      o_pixel_x,
    output logic signed [COORD_BITS-1:0]      o_pixel_y,
    output logic                              o_last
);
    localparam int CB = COORD_BITS;
    localparam int FB = DDA_FRAC_BITS;
    localparam int QB = FB + 1;        // quotient bits
    localparam int RW = CB + 2;        // divider remainder / direct remainder
    localparam int NW = CB + FB + 2;   // dividend
    localparam int AW = CB + FB + 1;   // accumulator
    localparam int SW = FB + 2;        // signed slope
    localparam int DW = CB + 3;        // decision

    // ---- setup from the load beat ----
    logic signed [CB:0]   dx, dy, adx, ady, ndx, ndy, dmaj, dmin;
    logic [CB:0]          amin;
    logic                 major_y, swap;
    logic signed [CB-1:0] msx, msy, mex, mey, minor0;
    logic signed [DW-1:0] dec0;
    logic signed [CB+1:0] incd0, incs0;
    logic [NW-1:0]        num;
    logic signed [AW-1:0] acc0;

    always_comb begin
        dx      = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
        dy      = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
        adx     = dx[CB] ? -dx : dx;
        ady     = dy[CB] ? -dy : dy;
        major_y = ady > adx;
        swap    = major_y ? dy[CB] : dx[CB];
        ndx     = swap ? -dx : dx;
        ndy     = swap ? -dy : dy;
        msx     = swap ? i_end_x : i_start_x;
        msy     = swap ? i_end_y : i_start_y;
        mex     = swap ? i_start_x : i_end_x;
        mey     = swap ? i_start_y : i_end_y;
        dmaj    = major_y ? ndy : ndx;
        dmin    = major_y ? ndx : ndy;
        amin    = major_y ? $unsigned(adx) : $unsigned(ady);
        minor0  = major_y ? msx : msy;
        dec0    = {{2{dmaj[CB]}}, dmaj} - $signed({1'b0, amin, 1'b0});
        incd0   = $signed({dmaj, 1'b0}) - $signed({amin, 1'b0});
        incs0   = $signed((CB+2)'(0)) - $signed({amin, 1'b0});
        num     = {amin, {QB{1'b0}}} + NW'($unsigned(dmaj));
        acc0    = {minor0[CB-1], minor0, {FB{1'b0}}};
    end

    assign o_sts.need_div = (i_method == METH_DDA) && (dmaj != '0);

    // ---- registers ----
    t_method              r_method;
    logic                 r_major_y, r_step_up, r_sneg;
    logic signed [CB-1:0] r_cur_x, r_cur_y, r_major_end, r_base;
    logic signed [DW-1:0] r_dec;
    logic signed [CB+1:0] r_incd, r_incs;
    logic signed [CB:0]   r_dmaj, r_dmin;
    logic signed [AW-1:0] r_acc;
    logic signed [RW-1:0] r_rem;
    logic [RW-1:0]        r_drem, r_dsor;
    logic [QB-1:0]        r_dlo, r_q;

    // ---- divider step (restoring, one quotient bit) ----
    logic [RW-1:0] dtry, n_drem;
    logic          qbit;
    always_comb begin
        dtry   = {r_drem[RW-2:0], r_dlo[QB-1]};
        qbit   = dtry >= r_dsor;
        n_drem = qbit ? dtry - r_dsor : dtry;
    end

    // ---- stepping ----
    logic signed [SW-1:0] slope;
    logic signed [AW-1:0] n_acc;
    logic [AW-1:0]        amag, rsum;
    logic [CB-1:0]        rint;
    logic signed [CB-1:0] dda_minor, mid_minor, dir_minor, cur_minor, n_minor, n_base;
    logic signed [DW-1:0] n_dec;
    logic signed [RW-1:0] dmajx, rem1, n_rem;
    logic signed [RW:0]   twice;

    always_comb begin
        slope     = r_sneg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        n_acc     = r_acc + {{(AW-SW){slope[SW-1]}}, slope};
        amag      = n_acc[AW-1] ? $unsigned(-n_acc) : $unsigned(n_acc);
        rsum      = amag + (AW'(1) << (FB - 1));
        rint      = rsum[FB+CB-1:FB];
        dda_minor = n_acc[AW-1] ? -$signed(rint) : $signed(rint);

        cur_minor = r_major_y ? r_cur_x : r_cur_y;
        if (r_dec[DW-1] || (r_dec == '0)) begin
            n_dec     = r_dec + {r_incd[CB+1], r_incd};
            mid_minor = r_step_up ? cur_minor + CB'(1) : cur_minor - CB'(1);
        end else begin
            n_dec     = r_dec + {r_incs[CB+1], r_incs};
            mid_minor = cur_minor;
        end

        dmajx = {r_dmaj[CB], r_dmaj};
        rem1  = r_rem + {r_dmin[CB], r_dmin};
        if (rem1 >= dmajx) begin
            n_rem  = rem1 - dmajx;
            n_base = r_base + CB'(1);
        end else if (rem1[RW-1]) begin
            n_rem  = rem1 + dmajx;
            n_base = r_base - CB'(1);
        end else begin
            n_rem  = rem1;
            n_base = r_base;
        end
        twice = {n_rem, 1'b0};
        if (twice > {dmajx[RW-1], dmajx}) begin
            dir_minor = n_base + CB'(1);
        end else if (twice < {dmajx[RW-1], dmajx}) begin
            dir_minor = n_base;
        end else begin
            dir_minor = n_base[CB-1] ? n_base : n_base + CB'(1);
        end

        case (r_method)
            METH_MID: n_minor = mid_minor;
            METH_DDA: n_minor = dda_minor;
            default:  n_minor = dir_minor;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_method    <= i_method;
            r_major_y   <= major_y;
            r_cur_x     <= msx;
            r_cur_y     <= msy;
            r_major_end <= major_y ? mey : mex;
            r_step_up   <= !dmin[CB] && (dmin != '0);
            r_dec       <= dec0;
            r_incd      <= incd0;
            r_incs      <= incs0;
            r_dmaj      <= dmaj;
            r_dmin      <= dmin;
            r_acc       <= acc0;
            r_base      <= minor0;
            r_rem       <= '0;
            r_drem      <= RW'(num[NW-1:QB]);
            r_dlo       <= num[QB-1:0];
            r_q         <= '0;
            r_dsor      <= {1'b0, dmaj[CB-1:0], 1'b0};
            r_sneg      <= dmin[CB];
        end else if (i_cmd.div_step) begin
            r_drem <= n_drem;
            r_dlo  <= {r_dlo[QB-2:0], 1'b0};
            r_q    <= {r_q[QB-2:0], qbit};
        end else if (i_cmd.advance) begin
            r_dec  <= n_dec;
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_base <= n_base;
            if (r_major_y) begin
                r_cur_y <= r_cur_y + CB'(1);
                r_cur_x <= n_minor;
            end else begin
                r_cur_x <= r_cur_x + CB'(1);
                r_cur_y <= n_minor;
            end
        end
    end

    assign o_sts.fin = (r_major_y ? r_cur_y : r_cur_x) >= r_major_end;
    assign o_pixel_x = r_cur_x;
    assign o_pixel_y = r_cur_y;
    assign o_last    = o_sts.fin;
endmodule
`default_nettype wire

FILE: hdl/lr3_ctrl.sv
// Controller: accepts beats, sequences setup, slope division and pixel emission.
// Depends on lr3_pkg.
`default_nettype none
module lr3_ctrl
    import lr3_pkg::*;
#(
    parameter int DIV_STEPS = DDA_FRAC_BITS_DEF + 1
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_kind,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire logic    i_method_none,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);
    localparam int CW = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} t_state;

    t_state        r_state;
    logic          r_active;
    logic [CW-1:0] r_cnt;
    logic          in_beat, out_beat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_beat    = o_out_valid && i_out_ready;

    always_comb begin
        o_cmd.load     = in_beat && (i_in_kind == KIND_LOAD) && !i_method_none;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.advance  = out_beat && !i_sts.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (i_in_kind == KIND_LOAD) begin
                            r_active <= !i_method_none;
                            if (i_method_none) begin
                                r_state <= S_IDLE;
                            end else if (i_sts.need_div) begin
                                r_state <= S_DIV;
                                r_cnt   <= CW'(DIV_STEPS - 1);
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end else if (r_active) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_beat) begin
                        r_state <= S_IDLE;
                        if (i_sts.fin) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/line_rasterizer_three_mode.sv
// Line rasterizer, one segment at a time, midpoint / DDA / direct placement.
// Load beat: no pixel for method none; else first pixel in the cycle after
// accept, but non-degenerate DDA first runs the restoring slope divider (one
// quotient bit per cycle). Tick beat: if a line is active, pixel in the cycle
// after accept; next beat taken only once it drains, never while a pixel waits.
// Sync active-low reset: no line active, line_method = midpoint, color = 0.
`default_nettype none
module line_rasterizer_three_mode
    import lr3_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DDA_FRAC_BITS = DDA_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lr3_in_if.sink                     i_in,
    lr3_out_if.source                  o_pix,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    // Configuration registers; write only while idle (the block does not enforce it).
    t_method            r_line_method;
    logic [COLOR_W-1:0] r_draw_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_method <= METH_MID;
            r_draw_color  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_METHOD: r_line_method <= t_method'(i_cfg_data[1:0]);
                REG_DRAW_COLOR:  r_draw_color  <= i_cfg_data[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: owns the handshakes and the "line active" flag.
    lr3_ctrl #(
        .DIV_STEPS (DDA_FRAC_BITS + 1)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_kind     (i_in.kind),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_pix.valid),
        .i_out_ready   (o_pix.ready),
        .i_method_none (r_line_method == METH_NONE),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // Datapath: setup, divider, and the three minor-axis steppers.
    lr3_dp #(
        .COORD_BITS    (COORD_BITS),
        .DDA_FRAC_BITS (DDA_FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_method  (r_line_method),
        .i_start_x (i_in.start_x),
        .i_start_y (i_in.start_y),
        .i_end_x   (i_in.end_x),
        .i_end_y   (i_in.end_y),
        .o_sts     (sts),
        .o_pixel_x (o_pix.pixel_x),
        .o_pixel_y (o_pix.pixel_y),
        .o_last    (o_pix.last)
    );

    // Color is the live register value; a write while a pixel waits changes it.
    assign o_pix.color = r_draw_color;
endmodule
`default_nettype wire

FILE: hdl/lr3_checker.sv
// Port-level checks for line_rasterizer_three_mode, plus the bind.
// Depends on lr3_pkg and line_rasterizer_three_mode_assert.svh.
`default_nettype none
`include "line_rasterizer_three_mode_assert.svh"
module lr3_checker
    import lr3_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [COORD_BITS-1:0] i_pixel_x,
    input wire logic signed [COORD_BITS-1:0] i_pixel_y,
    input wire logic                         i_last
);
    `LR3_ASSERT_NOW(a_one_at_a_time, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `LR3_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last, !i_out_valid && i_in_ready)
    `LR3_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `LR3_ASSERT_NEXT(a_pixel_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_pixel_x) && $stable(i_pixel_y) && $stable(i_last))
endmodule

bind line_rasterizer_three_mode lr3_checker #(
    .COORD_BITS (COORD_BITS)
) u_lr3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pixel_x   (o_pix.pixel_x),
    .i_pixel_y   (o_pix.pixel_y),
    .i_last      (o_pix.last)
);
`default_nettype wire

FILE: tb/sv/lr3_tb_pkg.sv
// Beat type for the line rasterizer bench: one stimulus beat as queued by the test.
// Depends on lr3_pkg.
package lr3_tb_pkg;
    import lr3_pkg::*;

    typedef struct {
        logic                 kind;
        logic signed [11:0]   sx;
        logic signed [11:0]   sy;
        logic signed [11:0]   ex;
        logic signed [11:0]   ey;
    } t_line_beat;

    typedef struct {
        logic signed [11:0]   px;
        logic signed [11:0]   py;
        logic [COLOR_W-1:0]   color;
        logic                 last;
    } t_pixel;
endpackage

FILE: tb/sv/line_rasterizer_three_mode_tb.sv
// Self-checking bench for line_rasterizer_three_mode: loads and ticks go in,
// pixels come out and are compared against a built-in line tracer.
// Depends on lr3_pkg, lr3_tb_pkg, lr3_in_if, lr3_out_if and the rasterizer RTL.
module line_rasterizer_three_mode_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lr3_pkg::*;
    import lr3_tb_pkg::*;

    localparam int FRAC = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_LINE_METHOD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    lr3_in_if  line_ch ();
    lr3_out_if pix_ch ();

    line_rasterizer_three_mode dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(line_ch.sink), .o_pix(pix_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------- tracer state: mirrors the block's line walker ----------
    t_method       cfg_method = METH_MID;
    logic [23:0]   cfg_color = '0;
    t_method       run_meth;
    bit            tr_active;
    bit            tr_major_y;
    bit            tr_up;
    longint        tr_x, tr_y, tr_end, tr_dec, tr_inc_diag, tr_inc_str;
    longint        tr_acc, tr_slope, tr_base, tr_rem, tr_dmaj, tr_dmin;

    t_line_beat    pending_beats[$];
    t_pixel        expected_pixels[$];
    int            mismatches = 0;
    int            pixels_seen = 0;
    int            loads_sent = 0;
    bit            idle_on = 1'b1;

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_q20(longint a);
        longint half;
        half = longint'(1) << (FRAC - 1);
        if (a >= 0) return (a + half) >>> FRAC;
        return -((-a + half) >>> FRAC);
    endfunction

    // Move the walker one step along the major axis and place the minor coordinate.
    task automatic step_line();
        longint minor;
        minor = 0;
        if (tr_major_y) tr_y++; else tr_x++;
        case (run_meth)
            METH_MID: begin
                minor = tr_major_y ? tr_x : tr_y;
                if (tr_dec <= 0) begin
                    tr_dec += tr_inc_diag;
                    minor += tr_up ? 1 : -1;
                end else begin
                    tr_dec += tr_inc_str;
                end
            end
            METH_DDA: begin
                tr_acc += tr_slope;
                minor = round_q20(tr_acc);
            end
            default: begin
                tr_rem += tr_dmin;
                if (tr_rem >= tr_dmaj) begin
                    tr_rem -= tr_dmaj;
                    tr_base++;
                end else if (tr_rem < 0) begin
                    tr_rem += tr_dmaj;
                    tr_base--;
                end
                // exact rational rounding, ties away from zero
                if (2 * tr_rem > tr_dmaj) minor = tr_base + 1;
                else if (2 * tr_rem < tr_dmaj) minor = tr_base;
                else minor = tr_base >= 0 ? tr_base + 1 : tr_base;
            end
        endcase
        if (tr_major_y) tr_x = minor; else tr_y = minor;
    endtask

    task automatic emit_pixel();
        t_pixel p;
        bit fin;
        fin = (tr_major_y ? tr_y : tr_x) >= tr_end;
        p.px = tr_x[11:0];
        p.py = tr_y[11:0];
        p.color = cfg_color;
        p.last = fin;
        expected_pixels.push_back(p);
        if (fin) tr_active = 0; else step_line();
    endtask

    task automatic trace_beat(t_line_beat b);
        longint sx, sy, ex, ey, dx, dy, t, mag, q;
        if (b.kind == KIND_TICK) begin
            if (tr_active) emit_pixel();
            return;
        end
        tr_active = 0;
        run_meth = cfg_method;
        if (run_meth == METH_NONE) return;
        sx = b.sx; sy = b.sy; ex = b.ex; ey = b.ey;
        dx = ex - sx; dy = ey - sy;
        tr_major_y = abs64(dy) > abs64(dx);
        // swap so the major coordinate steps upward
        if (tr_major_y ? (dy < 0) : (dx < 0)) begin
            t = sx; sx = ex; ex = t;
            t = sy; sy = ey; ey = t;
            dx = -dx; dy = -dy;
        end
        tr_dmaj = tr_major_y ? dy : dx;
        tr_dmin = tr_major_y ? dx : dy;
        tr_end = tr_major_y ? ey : ex;
        tr_x = sx; tr_y = sy;
        tr_up = tr_dmin > 0;
        tr_dec = tr_dmaj - 2 * abs64(tr_dmin);
        tr_inc_diag = 2 * tr_dmaj - 2 * abs64(tr_dmin);
        tr_inc_str = -2 * abs64(tr_dmin);
        tr_acc = (tr_major_y ? sx : sy) * (longint'(1) << FRAC);
        tr_slope = 0;
        if (tr_dmaj > 0) begin
            mag = abs64(tr_dmin) * (longint'(1) << FRAC);
            q = (2 * mag + tr_dmaj) / (2 * tr_dmaj);
            tr_slope = tr_dmin < 0 ? -q : q;
        end
        tr_base = tr_major_y ? sx : sy;
        tr_rem = 0;
        tr_active = 1;
        emit_pixel();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR pixel %0d: %s got %0d want %0d", pixels_seen, what, got, want);
        mismatches++;
    endtask

    // ---------------- driver: feeds pending_beats with random gaps ------------
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_ch.valid <= 1'b0;
        end else begin
            if (line_ch.valid && line_ch.ready) begin
                trace_beat(pending_beats.pop_front());
            end
            if (!line_ch.valid || line_ch.ready) begin
                // the front beat is now the next to offer
                if (drv_gap > 0) begin
                    drv_gap--;
                    line_ch.valid <= 1'b0;
                end else if (pending_beats.size() > 0 && idle_on &&
                             $urandom_range(0, 5) == 0) begin
                    drv_gap = $urandom_range(0, 6);
                    line_ch.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    line_ch.valid   <= 1'b1;
                    line_ch.kind    <= pending_beats[0].kind;
                    line_ch.start_x <= pending_beats[0].sx;
                    line_ch.start_y <= pending_beats[0].sy;
                    line_ch.end_x   <= pending_beats[0].ex;
                    line_ch.end_y   <= pending_beats[0].ey;
                end else begin
                    line_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor: checks each accepted pixel beat ----------------
    int stall = 0;
    always @(posedge i_clk) begin
        t_pixel w;
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel x", pix_ch.pixel_x, 0);
                end else begin
                    w = expected_pixels.pop_front();
                    if (pix_ch.pixel_x !== w.px) report_mismatch("x", pix_ch.pixel_x, w.px);
                    if (pix_ch.pixel_y !== w.py) report_mismatch("y", pix_ch.pixel_y, w.py);
                    if (pix_ch.color !== w.color) report_mismatch("color", pix_ch.color, w.color);
                    if (pix_ch.last !== w.last) report_mismatch("last", pix_ch.last, w.last);
                end
            end
            if (stall > 0) begin
                stall--;
                pix_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(0, 6);
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus helpers --------------------------------------
    function automatic t_line_beat make_load(int sx, int sy, int ex, int ey);
        t_line_beat b;
        b.kind = KIND_LOAD;
        b.sx = 12'(sx); b.sy = 12'(sy); b.ex = 12'(ex); b.ey = 12'(ey);
        return b;
    endfunction

    function automatic t_line_beat make_tick();
        t_line_beat b;
        b.kind = KIND_TICK;
        b.sx = 12'($urandom); b.sy = 12'($urandom);
        b.ex = 12'($urandom); b.ey = 12'($urandom);
        return b;
    endfunction

    function automatic int rnd_coord();
        return $signed(12'($urandom));
    endfunction

    // Line whose longer axis spans at most 'span' pixels; sometimes placed at edges.
    task automatic queue_line(int span, int ticks);
        int sx, sy, dx, dy;
        sx = rnd_coord(); sy = rnd_coord();
        dx = $urandom_range(0, 2 * span) - span;
        dy = $urandom_range(0, 2 * span) - span;
        if (sx + dx > 2047 || sx + dx < -2048) dx = -dx;
        if (sy + dy > 2047 || sy + dy < -2048) dy = -dy;
        pending_beats.push_back(make_load(sx, sy, sx + dx, sy + dy));
        loads_sent++;
        repeat (ticks) pending_beats.push_back(make_tick());
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || line_ch.valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);  // room for a DDA divide still in flight
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_LINE_METHOD) cfg_method = t_method'(data[1:0]);
        else cfg_color = data;
    endtask

    // Directed corners: extremes, degenerate, both major axes in both directions, abandon, idle ticks.
    task automatic queue_corners();
        pending_beats.push_back(make_tick());                     // nothing active after reset
        pending_beats.push_back(make_load(5, 5, 5, 5));           // single pixel
        pending_beats.push_back(make_tick());
        pending_beats.push_back(make_load(2047, -2048, 2044, -2046));
        repeat (3) pending_beats.push_back(make_tick());
        pending_beats.push_back(make_load(-2048, 2047, -2045, 2043));
        pending_beats.push_back(make_tick());
        pending_beats.push_back(make_load(0, 0, -3, -3));         // tie goes to x
        repeat (4) pending_beats.push_back(make_tick());
        pending_beats.push_back(make_load(1, 0, -1, 5));          // y-major, minor steps down
        repeat (6) pending_beats.push_back(make_tick());
        pending_beats.push_back(make_load(-2048, -2048, 2047, 2047));
        pending_beats.push_back(make_tick());
    endtask

    // ---------------- main sequence -----------------------------------------
    initial begin
        int colors[4];
        t_method plan[8];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting first (midpoint, black)
        queue_corners();
        wait_drained();

        colors = '{24'h000000, 24'hFFFFFF, 24'hA5A5A5, 24'h5A5A5A};
        plan = '{METH_DDA, METH_DIRECT, METH_NONE, METH_MID,
                 METH_DDA, METH_DIRECT, METH_MID, METH_DDA};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_LINE_METHOD, 24'(plan[ph]));
            write_reg(REG_DRAW_COLOR, ph < 4 ? 24'(colors[ph]) : 24'($urandom));
            if (ph < 4) queue_corners();
            if (ph == 7) idle_on = 0;   // last stretch runs without gaps
            for (int n = 0; n < 21; n++) begin
                int r;
                r = $urandom_range(0, 19);
                if (r == 0) queue_line(2047, $urandom_range(0, 3));       // long, abandoned
                else if (r == 1) queue_line(8, $urandom_range(0, 3));     // broken / short
                else if (r == 2) pending_beats.push_back(make_tick());    // stray tick
                else queue_line($urandom_range(0, 6), 8);                 // run to the end
            end
            // color applies per pixel; it only changes after a full drain
            wait_drained();
        end

        $display("Covered %0d loads and %0d pixel beats across all methods and colors.",
                 loads_sent, pixels_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d pixels still expected", expected_pixels.size());
        $display("Mismatches found");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/lr3_pkg.sv
hdl/lr3_in_if.sv
hdl/lr3_out_if.sv
hdl/lr3_dp.sv
hdl/lr3_ctrl.sv
hdl/line_rasterizer_three_mode.sv
hdl/lr3_checker.sv
tb/sv/lr3_tb_pkg.sv
tb/sv/line_rasterizer_three_mode_tb.sv
